>>> rtl/core/dcpf_pkg.sv
// Shared types and constants for the divisor count unit.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none
package dcpf_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int COUNT_BITS     = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_NEW_GO,
    ST_NEW_RUN,
    ST_REP_GO,
    ST_REP_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic init_odd;
    logic div_start;
    logic take_quo;
    logic next_cand;
    logic emit_zero;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic value_zero;
    logic value_even;
    logic div_done;
    logic cand_le_quo;
    logic rem_zero;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/dcpf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; instantiated by dcpf_datapath.
`default_nettype none
module dcpf_div #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       running,
  output logic      [VALUE_BITS-1:0] quotient,
  output logic      [VALUE_BITS-1:0] remainder
);

  localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

  logic [STEP_BITS-1:0]  step;
  logic [VALUE_BITS-1:0] dvsr;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  assign trial = {remainder, quotient[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      step    <= STEP_BITS'(VALUE_BITS);
    end else if (running) begin
      step <= step - STEP_BITS'(1);
      if (step == STEP_BITS'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvsr      <= divisor;
    end else if (running) begin
      if (fits) begin
        remainder <= diff[VALUE_BITS-1:0];
        quotient  <= {quotient[VALUE_BITS-2:0], 1'b1};
      end else begin
        remainder <= trial[VALUE_BITS-1:0];
        quotient  <= {quotient[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dcpf_datapath.sv
// Datapath: remaining value, candidate, exponent, running count, result word.
// Depends on dcpf_pkg and dcpf_div.
`default_nettype none
module dcpf_datapath
  import dcpf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] number,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       done,
  output logic      [COUNT_BITS-1:0] divisor_count
);

  localparam int EXPO_BITS = $clog2(VALUE_BITS + 1);
  localparam int PROD_BITS = COUNT_BITS + EXPO_BITS;

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] cand;
  logic [EXPO_BITS-1:0]  expo;
  logic [COUNT_BITS-1:0] count;
  logic                  div_running;
  logic [VALUE_BITS-1:0] quotient;
  logic [VALUE_BITS-1:0] remainder;
  logic [EXPO_BITS-1:0]  factor;
  logic [PROD_BITS-1:0]  prod;
  logic [COUNT_BITS-1:0] prod_sat;

  dcpf_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (value),
    .divisor  (cand),
    .running  (div_running),
    .quotient (quotient),
    .remainder(remainder)
  );

  // final step doubles the count when a prime above the bound remains
  always_comb begin
    if (cmd.emit_final) begin
      factor = (|value[VALUE_BITS-1:1]) ? EXPO_BITS'(2) : EXPO_BITS'(1);
    end else begin
      factor = expo + EXPO_BITS'(1);
    end
    prod     = {{EXPO_BITS{1'b0}}, count} * {{COUNT_BITS{1'b0}}, factor};
    prod_sat = (|prod[PROD_BITS-1:COUNT_BITS]) ? '1 : prod[COUNT_BITS-1:0];
  end

  always_comb begin
    status.value_zero  = (value == '0);
    status.value_even  = ~value[0];
    status.div_done    = ~div_running;
    status.cand_le_quo = (cand <= quotient);
    status.rem_zero    = (remainder == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= number;
      expo  <= '0;
      count <= COUNT_BITS'(1);
    end else if (cmd.shift) begin
      value <= {1'b0, value[VALUE_BITS-1:1]};
      expo  <= expo + EXPO_BITS'(1);
    end else if (cmd.init_odd) begin
      count <= prod_sat;
      expo  <= '0;
      cand  <= VALUE_BITS'(3);
    end else if (cmd.take_quo) begin
      value <= quotient;
      expo  <= expo + EXPO_BITS'(1);
    end else if (cmd.next_cand) begin
      count <= prod_sat;
      expo  <= '0;
      cand  <= cand + VALUE_BITS'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_zero | cmd.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      divisor_count <= '0;
    end else if (cmd.emit_final) begin
      divisor_count <= prod_sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dcpf_ctrl.sv
// Controller FSM: sequences strip-twos, trial divisions and result write.
// Depends on dcpf_pkg.
`default_nettype none
module dcpf_ctrl
  import dcpf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (status.value_zero) begin
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end else if (status.value_even) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.init_odd = 1'b1;
          state_next   = ST_NEW_GO;
        end
      end
      ST_NEW_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_NEW_RUN;
      end
      // first division of a candidate also gives the bound test
      ST_NEW_RUN: begin
        if (status.div_done) begin
          if (!status.cand_le_quo) begin
            cmd.emit_final = 1'b1;
            state_next     = ST_IDLE;
          end else if (status.rem_zero) begin
            cmd.take_quo = 1'b1;
            state_next   = ST_REP_GO;
          end else begin
            cmd.next_cand = 1'b1;
            state_next    = ST_NEW_GO;
          end
        end
      end
      ST_REP_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_REP_RUN;
      end
      // repeated division by the same candidate: no bound test
      ST_REP_RUN: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.take_quo = 1'b1;
            state_next   = ST_REP_GO;
          end else begin
            cmd.next_cand = 1'b1;
            state_next    = ST_NEW_GO;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/divisor_count_prime_factorization_unit.sv
// Zero is answered from the strip state; otherwise trailing zero bits are shifted out, then a
// trial division runs once per odd candidate plus once per factor found.
// Worst case at 31 bits is about 23,000 candidates; the single bit-serial divider
// sets the run time. One word in flight; done pulses one cycle.
// Synchronous active-high reset returns the controller to idle with done low.
// The receiver cannot stall; divisor_count holds each count until the next result.
`default_nettype none
module divisor_count_prime_factorization_unit
  import dcpf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] number,
  output logic                       busy,
  output logic                       done,
  output logic      [COUNT_BITS-1:0] divisor_count
);

  cmd_t    cmd;
  status_t status;

  dcpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  dcpf_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .number       (number),
    .cmd          (cmd),
    .status       (status),
    .done         (done),
    .divisor_count(divisor_count)
  );

endmodule
`default_nettype wire
